// File: rtl/beog_pkg.sv
// Package: shared constants and types for the eased opacity generator
package beog_pkg;

    localparam int TIME_BITS_DEF    = 24;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int BISECT_STEPS_DEF = 12;
    localparam int REG_BITS         = 24;

    // Register indexes of the configuration port
    localparam logic REG_PULSE_PERIOD   = 1'b0;
    localparam logic REG_FLASH_DURATION = 1'b1;

    // Curve selector
    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_FLASH = 1'b1;

    localparam logic [REG_BITS-1:0] PULSE_PERIOD_RST   = 24'd1000;
    localparam logic [REG_BITS-1:0] FLASH_DURATION_RST = 24'd300;

    // Post-processing selector for the ease value
    typedef enum logic [1:0] {
        t_POST_FALL  = 2'd0,
        t_POST_RISE  = 2'd1,
        t_POST_FLASH = 2'd2
    } t_post;

endpackage

// File: rtl/bezier_eased_opacity_generator.sv
// Top level: eased opacity generator, divider and bisection pipelines with output register
//
//  channel    | direction | beat contents
//  -----------+-----------+---------------------------------------------------
//  s_axis     | in        | tuser: command; tdata: elapsed_ticks
//  m_axis     | out       | tdata: opacity
//  cfg write  | in        | index 0 pulse_period, index 1 flash_duration
//
// One beat enters per cycle unless the sink stalls. The pipeline holds NB+1 modulo divider stages
// (NB = max(TIME_BITS,24)), 1 remainder stage, NB+FRAC_BITS+1 phase divider stages, 1 wrap
// stage, 4*BISECT_STEPS+3 bisection stages and 2 output stages; the two bit-serial dividers and
// the bisection steps set that depth. Reset (synchronous, active low) empties the pipeline and
// loads the register defaults. The pipeline advances when the output register is empty or taken;
// a stalled sink freezes all stages, nothing lost.
module bezier_eased_opacity_generator #(
    parameter int TIME_BITS    = beog_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS    = beog_pkg::FRAC_BITS_DEF,
    parameter int BISECT_STEPS = beog_pkg::BISECT_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0] s_axis_tdata,   // [TIME_BITS-1:0] elapsed_ticks
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] opacity
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    localparam int RB = beog_pkg::REG_BITS;
    localparam int NB = (TIME_BITS > RB) ? TIME_BITS : RB;
    localparam int QW = NB + FRAC_BITS;
    localparam int W  = FRAC_BITS + 2;
    localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] HALF = ONE >> 1;
    localparam logic [W-1:0] C42 = W'(((64'd42 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [W-1:0] C40 = W'(((64'd40 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [W-1:0] C80 = W'(((64'd80 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [W-1:0] SPAN = ONE - C40;

    logic [RB-1:0] r_period, r_duration;
    logic          w_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= beog_pkg::PULSE_PERIOD_RST;
            r_duration <= beog_pkg::FLASH_DURATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                beog_pkg::REG_PULSE_PERIOD:   r_period   <= i_cfg_data;
                beog_pkg::REG_FLASH_DURATION: r_duration <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [RB-1:0] w_p, w_d;
    assign w_p = (r_period   == '0) ? RB'(1) : r_period;
    assign w_d = (r_duration == '0) ? RB'(1) : r_duration;

    // Stage 0: take the time field at the working width
    logic [NB-1:0] w_t;
    assign w_t = NB'(s_axis_tdata[TIME_BITS-1:0]);

    // First divider: integer quotient floor(t/P), from which t mod P is formed
    logic            w_q1_v;
    logic [NB-1:0]   w_q1;
    logic [2*NB:0]   w_q1_tag;
    beog_div #(.NUM_BITS(NB), .FRAC_BITS(0), .TAG_BITS(2*NB+1)) u_mod (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(s_axis_tvalid && s_axis_tready),
        .i_num(w_t),
        .i_den(NB'(w_p)),
        .i_tag({s_axis_tuser, NB'(w_d), w_t}),
        .o_valid(w_q1_v), .o_quot(w_q1), .o_tag(w_q1_tag)
    );

    // Remainder and numerator selection
    logic          r_m_v, r_m_cmd;
    logic [NB-1:0] r_m_num, r_m_den;
    logic [2*NB-1:0] w_qp;
    logic [NB-1:0] w_tt;
    logic          w_cmd;
    assign w_cmd = w_q1_tag[2*NB];
    assign w_tt  = w_q1_tag[NB-1:0];
    assign w_qp  = w_q1 * NB'(w_p);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= w_q1_v;
        end
        if (w_en) begin
            r_m_cmd <= w_cmd;
            if (w_cmd == beog_pkg::CMD_PULSE) begin
                r_m_num <= w_tt - w_qp[NB-1:0];
                r_m_den <= NB'(w_p);
            end else begin
                r_m_num <= w_tt;
                r_m_den <= w_q1_tag[NB +: NB];
            end
        end
    end

    // Second divider: phase or flash time
    logic          w_q2_v;
    logic [QW-1:0] w_q2;
    logic [0:0]    w_q2_tag;
    beog_div #(.NUM_BITS(NB), .FRAC_BITS(FRAC_BITS), .TAG_BITS(1)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(r_m_v), .i_num(r_m_num), .i_den(r_m_den), .i_tag(r_m_cmd),
        .o_valid(w_q2_v), .o_quot(w_q2), .o_tag(w_q2_tag)
    );

    // Map to ease input and curve kind
    logic         r_w_v;
    logic [W-1:0] r_w_time, r_w_x1;
    logic [1:0]   r_w_post;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else if (w_en) begin
            r_w_v <= w_q2_v;
        end
        if (w_en) begin
            if (w_q2_tag[0] == beog_pkg::CMD_PULSE) begin
                r_w_x1 <= C42;
                if (w_q2 < QW'(HALF)) begin
                    r_w_time <= W'({w_q2, 1'b0});
                    r_w_post <= beog_pkg::t_POST_FALL;
                end else begin
                    r_w_time <= W'({w_q2 - QW'(HALF), 1'b0});
                    r_w_post <= beog_pkg::t_POST_RISE;
                end
            end else begin
                r_w_x1 <= '0;
                r_w_time <= (w_q2 >= QW'(ONE)) ? ONE : W'(w_q2);
                r_w_post <= beog_pkg::t_POST_FLASH;
            end
        end
    end

    logic         w_e_v;
    logic [W-1:0] w_e;
    logic [1:0]   w_e_post;
    beog_bisect #(.FRAC_BITS(FRAC_BITS), .BISECT_STEPS(BISECT_STEPS), .TAG_BITS(2)) u_bis (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(r_w_v), .i_time(r_w_time), .i_x1(r_w_x1), .i_tag(r_w_post),
        .o_valid(w_e_v), .o_ease(w_e), .o_tag(w_e_post)
    );

    // Output mapping, two stages
    logic         r_p_v;
    logic [W-1:0] r_p_prod;
    logic [1:0]   r_p_post;
    logic [2*W-1:0] w_prod;
    logic [W-1:0] w_op;
    logic [15:0]  w_q16;
    logic [W+15:0] w_sh;
    logic         r_o_v;
    logic [15:0]  r_o_data;

    always_comb begin
        case (beog_pkg::t_post'(w_e_post))
            beog_pkg::t_POST_FLASH: w_prod = C80 * (ONE - w_e);
            default:                w_prod = SPAN * w_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v <= w_e_v;
        end
        if (w_en) begin
            r_p_prod <= w_prod[FRAC_BITS +: W];
            r_p_post <= w_e_post;
        end
    end

    always_comb begin
        case (beog_pkg::t_post'(r_p_post))
            beog_pkg::t_POST_FALL: w_op = ONE - r_p_prod;
            beog_pkg::t_POST_RISE: w_op = C40 + r_p_prod;
            default:               w_op = r_p_prod;
        endcase
        w_sh = (W+16)'(w_op) << 16;
        if ((w_sh >> FRAC_BITS) > (W+16)'(16'hFFFF)) begin
            w_q16 = 16'hFFFF;
        end else begin
            w_q16 = 16'(w_sh >> FRAC_BITS);
        end
    end

    // Output register
    assign w_en = !r_o_v || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_p_v;
        end
        if (w_en) begin
            r_o_data <= w_q16;
        end
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_data;

    // Stall holds the result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // Ready follows output register space
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    // Flash result never exceeds 0.8
    a_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v && r_p_post == beog_pkg::t_POST_FLASH |-> r_p_prod <= C80)
        else $error("flash opacity out of range");
endmodule

// File: rtl/beog_div.sv
// Pipelined restoring divider: quotient of (num << FRAC_BITS) / den, one bit per stage
module beog_div #(
    parameter int NUM_BITS  = 24,
    parameter int FRAC_BITS = 16,
    parameter int TAG_BITS  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [NUM_BITS-1:0]           i_num,
    input  logic [NUM_BITS-1:0]           i_den,
    input  logic [TAG_BITS-1:0]           i_tag,
    output logic                          o_valid,
    output logic [NUM_BITS+FRAC_BITS-1:0] o_quot,
    output logic [TAG_BITS-1:0]           o_tag
);
    localparam int QW = NUM_BITS + FRAC_BITS;
    localparam int RW = NUM_BITS + 1;

    logic [QW-1:0]       r_dvd  [QW+1];
    logic [QW-1:0]       r_quot [QW+1];
    logic [RW-1:0]       r_rem  [QW+1];
    logic [NUM_BITS-1:0] r_den  [QW+1];
    logic [TAG_BITS-1:0] r_tag  [QW+1];
    logic [QW:0]         r_vld;

    // Load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_dvd[0]  <= QW'(i_num) << FRAC_BITS;
            r_quot[0] <= '0;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_tag[0]  <= i_tag;
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0] w_sh;
        logic [RW:0]   w_diff;
        assign w_sh   = {r_rem[s][RW-2:0], r_dvd[s][QW-1]};
        assign w_diff = {1'b0, w_sh} - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_dvd[s+1]  <= {r_dvd[s][QW-2:0], 1'b0};
                r_quot[s+1] <= {r_quot[s][QW-2:0], ~w_diff[RW]};
                r_rem[s+1]  <= w_diff[RW] ? w_sh : w_diff[RW-1:0];
                r_den[s+1]  <= r_den[s];
                r_tag[s+1]  <= r_tag[s];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_quot[QW];
    assign o_tag   = r_tag[QW];
endmodule

// File: rtl/beog_bisect.sv
// Pipelined bisection of the bezier x curve and smoothstep of the found parameter
module beog_bisect #(
    parameter int FRAC_BITS    = 16,
    parameter int BISECT_STEPS = 12,
    parameter int TAG_BITS     = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [FRAC_BITS+1:0] i_time,
    input  logic [FRAC_BITS+1:0] i_x1,
    input  logic [TAG_BITS-1:0]  i_tag,
    output logic                 o_valid,
    output logic [FRAC_BITS+1:0] o_ease,
    output logic [TAG_BITS-1:0]  o_tag
);
    localparam int W = FRAC_BITS + 2;
    localparam int PW = 2 * W;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] X2  = W'(((64'd58 << FRAC_BITS) + 64'd50) / 64'd100);
    // Each bisection step: 4 sub-stages (t,u products; *t; *x; sum/compare)
    localparam int NS = BISECT_STEPS;

    // Per-step registers: lo, hi, time, x1, tag, flags
    logic [W-1:0]        r_lo   [NS+1];
    logic [W-1:0]        r_hi   [NS+1];
    logic [W-1:0]        r_tm   [NS+1];
    logic [W-1:0]        r_x1   [NS+1];
    logic [TAG_BITS-1:0] r_tag  [NS+1];
    logic [NS:0]         r_vld;

    function automatic logic [W-1:0] f_mul(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [PW-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: W];
    endfunction

    // Entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_lo[0]  <= '0;
            r_hi[0]  <= ONE;
            r_tm[0]  <= i_time;
            r_x1[0]  <= i_x1;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [W-1:0] w_t, w_u;
        // sub-stage registers
        logic [W-1:0] r_a_uu, r_a_ut, r_a_tt, r_a_t;
        logic [W-1:0] r_b_uut, r_b_utt, r_b_ttt;
        logic [W-1:0] r_c_x1p, r_c_x2p, r_c_ttt;
        logic [W-1:0] r_a_lo, r_a_hi, r_a_tm, r_a_x1;
        logic [W-1:0] r_b_lo, r_b_hi, r_b_tm, r_b_x1, r_b_t;
        logic [W-1:0] r_c_lo, r_c_hi, r_c_tm, r_c_x1, r_c_t;
        logic [TAG_BITS-1:0] r_a_tag, r_b_tag, r_c_tag;
        logic r_a_v, r_b_v, r_c_v;
        logic [W+2:0] w_x;

        assign w_t = W'(({1'b0, r_lo[k]} + {1'b0, r_hi[k]}) >> 1);
        assign w_u = ONE - w_t;
        assign w_x = (W+3)'(3) * (W+3)'(r_c_x1p) + (W+3)'(3) * (W+3)'(r_c_x2p)
                   + (W+3)'(r_c_ttt);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v <= 1'b0;
                r_b_v <= 1'b0;
                r_c_v <= 1'b0;
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_a_v <= r_vld[k];
                r_b_v <= r_a_v;
                r_c_v <= r_b_v;
                r_vld[k+1] <= r_c_v;
            end
            if (i_en) begin
                // first products
                r_a_uu <= f_mul(w_u, w_u);
                r_a_ut <= f_mul(w_u, w_t);
                r_a_tt <= f_mul(w_t, w_t);
                r_a_t <= w_t;
                r_a_lo <= r_lo[k]; r_a_hi <= r_hi[k]; r_a_tm <= r_tm[k];
                r_a_x1 <= r_x1[k]; r_a_tag <= r_tag[k];
                // times t
                r_b_uut <= f_mul(r_a_uu, r_a_t);
                r_b_utt <= f_mul(r_a_ut, r_a_t);
                r_b_ttt <= f_mul(r_a_tt, r_a_t);
                r_b_t <= r_a_t;
                r_b_lo <= r_a_lo; r_b_hi <= r_a_hi; r_b_tm <= r_a_tm;
                r_b_x1 <= r_a_x1; r_b_tag <= r_a_tag;
                // times control points
                r_c_x1p <= f_mul(r_b_uut, r_b_x1);
                r_c_x2p <= f_mul(r_b_utt, X2);
                r_c_ttt <= r_b_ttt;
                r_c_t <= r_b_t;
                r_c_lo <= r_b_lo; r_c_hi <= r_b_hi; r_c_tm <= r_b_tm;
                r_c_x1 <= r_b_x1; r_c_tag <= r_b_tag;
                // compare and narrow the bracket
                if (w_x < (W+3)'(r_c_tm)) begin
                    r_lo[k+1] <= r_c_t;
                    r_hi[k+1] <= r_c_hi;
                end else begin
                    r_lo[k+1] <= r_c_lo;
                    r_hi[k+1] <= r_c_t;
                end
                r_tm[k+1]  <= r_c_tm;
                r_x1[k+1]  <= r_c_x1;
                r_tag[k+1] <= r_c_tag;
            end
        end
    end

    // Smoothstep: mul(mul(t,t), 3 - 2t), two stages
    logic [W-1:0] w_tf;
    logic [W-1:0] r_s_tt, r_s_poly, r_e_out, r_s_tm;
    logic [TAG_BITS-1:0] r_s_tag, r_e_tag;
    logic r_s_v, r_e_v;
    assign w_tf = W'(({1'b0, r_lo[NS]} + {1'b0, r_hi[NS]}) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_s_v <= r_vld[NS];
            r_e_v <= r_s_v;
        end
        if (i_en) begin
            r_s_tt   <= f_mul(w_tf, w_tf);
            r_s_poly <= W'(3) * ONE - W'(2) * w_tf;
            r_s_tm   <= r_tm[NS];
            r_s_tag  <= r_tag[NS];
            if (r_s_tm == '0) begin
                r_e_out <= '0;
            end else if (r_s_tm >= ONE) begin
                r_e_out <= ONE;
            end else begin
                r_e_out <= f_mul(r_s_tt, r_s_poly);
            end
            r_e_tag <= r_s_tag;
        end
    end

    assign o_valid = r_e_v;
    assign o_ease  = r_e_out;
    assign o_tag   = r_e_tag;
endmodule

// File: test/opacity_checker.sv
// Checker: predicts eased opacity for each accepted input beat and compares output beats
module opacity_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] elapsed_ticks
    input  logic        s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] opacity
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int FB = 16;
    localparam int STEPS = 12;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam longint unsigned K042 = ((64'd42 << FB) + 50) / 100;
    localparam longint unsigned K058 = ((64'd58 << FB) + 50) / 100;
    localparam longint unsigned K040 = ((64'd40 << FB) + 50) / 100;
    localparam longint unsigned K080 = ((64'd80 << FB) + 50) / 100;

    logic [23:0] period_reg;
    logic [23:0] duration_reg;
    logic [15:0] opacity_queue[$];

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> FB;
    endfunction

    // Bisect the bezier x for the given time, then return smoothstep of the parameter
    function automatic longint unsigned bezier_ease(longint unsigned tm,
                                                    longint unsigned x1,
                                                    longint unsigned x2);
        longint unsigned lo, hi, p, u, x;
        lo = 0;
        hi = ONE;
        if (tm == 0) return 0;
        if (tm >= ONE) return ONE;
        for (int k = 0; k < STEPS; k++) begin
            p = (lo + hi) >> 1;
            u = ONE - p;
            x = 3 * qmul(qmul(qmul(u, u), p), x1) + 3 * qmul(qmul(qmul(u, p), p), x2)
                + qmul(qmul(p, p), p);
            if (x < tm) lo = p;
            else hi = p;
        end
        p = (lo + hi) >> 1;
        return qmul(qmul(p, p), 3 * ONE - 2 * p);
    endfunction

    function automatic logic [15:0] eased_opacity(logic cmd, logic [23:0] ticks);
        longint unsigned per, dur, ph, e, op, span;
        span = ONE - K040;
        if (cmd == beog_pkg::CMD_PULSE) begin
            per = (period_reg == 0) ? 1 : period_reg;
            ph = ((longint'(ticks) % per) << FB) / per;
            if (ph < (ONE >> 1)) begin
                e = bezier_ease(ph * 2, K042, K058);
                op = ONE - qmul(span, e);
            end else begin
                e = bezier_ease((ph - (ONE >> 1)) * 2, K042, K058);
                op = K040 + qmul(span, e);
            end
        end else begin
            dur = (duration_reg == 0) ? 1 : duration_reg;
            e = bezier_ease((longint'(ticks) << FB) / dur, 0, K058);
            op = qmul(K080, ONE - e);
        end
        return (op > 65535) ? 16'hFFFF : op[15:0];
    endfunction

    assign o_pending = opacity_queue.size();

    // Track registers, queue predictions, compare output beats
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            period_reg <= beog_pkg::PULSE_PERIOD_RST;
            duration_reg <= beog_pkg::FLASH_DURATION_RST;
            opacity_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == beog_pkg::REG_PULSE_PERIOD) period_reg <= i_cfg_data;
                else duration_reg <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                opacity_queue.push_back(eased_opacity(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (opacity_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected beat: opacity %0d", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = opacity_queue.pop_front();
                    if (want !== m_axis_tdata) begin
                        if (o_fail_count < 10)
                            $display("opacity mismatch: expected %0d got %0d",
                                     want, m_axis_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: test/testbench.sv
// Testbench top: stimulus, idling phases and verdict for the eased opacity generator
module testbench;
    localparam int LATENCY = (24 + 1) + 1 + (24 + 16 + 1) + 1 + (4 * 12 + 3) + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [23:0] elapsed_ticks
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] opacity
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [23:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    bezier_eased_opacity_generator i_dut (.*);

    opacity_checker i_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on total cycles
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Random backpressure on the output side
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one beat, with random gaps before it
    task automatic send_beat(input logic cmd, input logic [23:0] ticks);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= ticks;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random times: mostly within a few periods, sometimes anywhere
    function automatic logic [23:0] pick_ticks(logic [23:0] span);
        longint unsigned lim;
        lim = (span == 0) ? 4 : longint'(span) * 3;
        if (lim > 24'hFFFFFF || $urandom_range(9) == 0) return 24'($urandom);
        return 24'($urandom_range(int'(lim)));
    endfunction

    task automatic random_phase(input int count, input logic [23:0] per,
                                input logic [23:0] dur);
        logic cmd;
        for (int n = 0; n < count; n++) begin
            cmd = 1'($urandom_range(1));
            send_beat(cmd, pick_ticks(cmd == beog_pkg::CMD_PULSE ? per : dur));
        end
    endtask

    initial begin
        logic [23:0] per;
        logic [23:0] dur;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset defaults, field extremes, both curves around edges
        send_beat(beog_pkg::CMD_PULSE, 24'd0);
        send_beat(beog_pkg::CMD_PULSE, 24'd499);
        send_beat(beog_pkg::CMD_PULSE, 24'd500);
        send_beat(beog_pkg::CMD_PULSE, 24'd999);
        send_beat(beog_pkg::CMD_PULSE, 24'd1000);
        send_beat(beog_pkg::CMD_PULSE, 24'd250);
        send_beat(beog_pkg::CMD_PULSE, 24'hFFFFFF);
        send_beat(beog_pkg::CMD_FLASH, 24'd0);
        send_beat(beog_pkg::CMD_FLASH, 24'd1);
        send_beat(beog_pkg::CMD_FLASH, 24'd150);
        send_beat(beog_pkg::CMD_FLASH, 24'd299);
        send_beat(beog_pkg::CMD_FLASH, 24'd300);
        send_beat(beog_pkg::CMD_FLASH, 24'hFFFFFF);
        send_beat(beog_pkg::CMD_FLASH, 24'h555555);
        send_beat(beog_pkg::CMD_PULSE, 24'hAAAAAA);
        drain_pipe();

        // Zero period and duration behave as one tick
        write_reg(beog_pkg::REG_PULSE_PERIOD, 24'd0);
        write_reg(beog_pkg::REG_FLASH_DURATION, 24'd0);
        send_beat(beog_pkg::CMD_PULSE, 24'd7);
        send_beat(beog_pkg::CMD_FLASH, 24'd0);
        send_beat(beog_pkg::CMD_FLASH, 24'd1);
        drain_pipe();

        // Largest settings
        write_reg(beog_pkg::REG_PULSE_PERIOD, 24'hFFFFFF);
        write_reg(beog_pkg::REG_FLASH_DURATION, 24'hFFFFFF);
        send_beat(beog_pkg::CMD_PULSE, 24'h7FFFFF);
        send_beat(beog_pkg::CMD_PULSE, 24'hFFFFFE);
        send_beat(beog_pkg::CMD_FLASH, 24'hFFFFFE);
        send_beat(beog_pkg::CMD_FLASH, 24'h800000);
        drain_pipe();

        // Random phases with several settings and three idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 17; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                0: begin per = 24'd1; dur = 24'd1; end
                1: begin per = 24'd2; dur = 24'd3; end
                5: begin per = 24'hFFFFFF; dur = 24'hFFFFFF; end
                default: begin
                    per = 24'($urandom_range(1, 5000));
                    dur = 24'($urandom_range(1, 5000));
                end
            endcase
            write_reg(beog_pkg::REG_PULSE_PERIOD, per);
            write_reg(beog_pkg::REG_FLASH_DURATION, dur);
            random_phase(165, per, dur);
            drain_pipe();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: bezier_eased_opacity_generator.f
rtl/beog_pkg.sv
rtl/beog_div.sv
rtl/beog_bisect.sv
rtl/bezier_eased_opacity_generator.sv
test/opacity_checker.sv
test/testbench.sv
